@@ rtl/buddy_block_allocator_top_defines.svh @@
// Assertion macros for the buddy block allocator.
// Used by the top level; no other dependencies.
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset
`define BBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("buddy allocator check failed");
// Next-cycle implication, checked outside reset
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("buddy allocator check failed");
`else
`define BBA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/bba_pkg.sv @@
// Shared constants, types and helper functions of the buddy block allocator.
// No dependencies.
`default_nettype none
package bba_pkg;
	localparam int FRAMES    = 32;
	localparam int TOP_ORDER = $clog2(FRAMES);
	localparam int ORDERS    = TOP_ORDER + 1;
	localparam int ORD_W     = $clog2(ORDERS);
	localparam int START_W   = 5;
	localparam int SIZE_W    = 6;
	localparam int ROW_W     = FRAMES;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	typedef struct packed {
		logic               we;
		logic [ORD_W-1:0]   waddr;
		logic [ROW_W-1:0]   wdata;
		logic [ORD_W-1:0]   raddr;
	} mem_req_t;

	typedef struct packed {
		logic               valid;
		logic               success;
		logic [START_W-1:0] granted_start;
		logic [SIZE_W-1:0]  granted_size;
	} result_t;

	typedef struct packed {
		logic               found;
		logic [START_W-1:0] idx;
	} scan_t;

	// Smallest order whose block holds v frames (v up to the pool size)
	function automatic logic [ORD_W-1:0] ceil_order(input logic [SIZE_W-1:0] v);
		logic [ORD_W-1:0] n;
		n = ORD_W'(TOP_ORDER);
		for (int i = TOP_ORDER; i >= 0; i--) begin
			if ((SIZE_W'(1) << i) >= v)
				n = ORD_W'(i);
		end
		return n;
	endfunction

	// Lowest set bit of a free map row
	function automatic scan_t lowest_set(input logic [ROW_W-1:0] row);
		scan_t r;
		r = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (row[i]) begin
				r.found = 1'b1;
				r.idx   = START_W'(i);
			end
		end
		return r;
	endfunction

	// Frames of the aligned block of the given order that holds frame s
	function automatic logic [ROW_W-1:0] block_mask(input logic [START_W-1:0] s,
			input logic [ORD_W-1:0] ord);
		logic [ROW_W-1:0] m;
		for (int i = 0; i < ROW_W; i++)
			m[i] = ((START_W'(i) ^ s) >> ord) == '0;
		return m;
	endfunction

	function automatic logic [ROW_W-1:0] one_bit(input logic [START_W-1:0] idx);
		return ROW_W'(1) << idx;
	endfunction
endpackage
`default_nettype wire

@@ rtl/bba_in_if.sv @@
// Request channel of the buddy block allocator.
// Depends on bba_pkg for field widths.
`default_nettype none
interface bba_in_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [bba_pkg::SIZE_W-1:0]  request_frames;
	logic [bba_pkg::START_W-1:0] release_start;
	logic [bba_pkg::SIZE_W-1:0]  release_size;

	modport source (output valid, kind, request_frames, release_start, release_size,
		input ready);
	modport sink (input valid, kind, request_frames, release_start, release_size,
		output ready);
endinterface
`default_nettype wire

@@ rtl/bba_out_if.sv @@
// Response channel of the buddy block allocator.
// Depends on bba_pkg for field widths.
`default_nettype none
interface bba_out_if;
	logic                        valid;
	logic                        ready;
	logic                        success;
	logic [bba_pkg::START_W-1:0] granted_start;
	logic [bba_pkg::SIZE_W-1:0]  granted_size;

	modport source (output valid, success, granted_start, granted_size, input ready);
	modport sink (input valid, success, granted_start, granted_size, output ready);
endinterface
`default_nettype wire

@@ rtl/bba_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/bba_engine.sv @@
// Sequencer of the buddy block allocator: search, split, check and merge
// over the free map rows. Depends on bba_pkg and bba_in_if.
`default_nettype none
module bba_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	bba_in_if.sink                        req,
	input  logic [bba_pkg::ROW_W-1:0]     rdata,
	output bba_pkg::mem_req_t             mem,
	output bba_pkg::result_t              res,
	input  logic                          res_take
);
	import bba_pkg::*;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_A_RD, S_A_CHK, S_A_SPLIT,
		S_R_RD, S_R_CHK, S_M_RD, S_M_CHK, S_FIN
	} state_t;

	state_t               state_q;
	logic [ORD_W-1:0]     row_q;
	logic [ORD_W-1:0]     n_q;
	logic [ORD_W-1:0]     o_q;
	logic [START_W-1:0]   s_q;
	logic                 kind_q;
	logic                 ok_q;

	scan_t                scan;
	logic [START_W-1:0]   buddy_idx;
	logic [START_W-1:0]   split_idx;
	logic [ORD_W-1:0]     chk_order;
	logic                 conflict;
	logic                 merge_go;
	logic [ORD_W-1:0]     req_n;
	logic [ORD_W-1:0]     rel_o;
	logic                 alloc_bad;
	logic                 rel_bad;
	logic [SIZE_W-1:0]    sz_m1;

	// Decode an incoming item
	assign req_n     = ceil_order(req.request_frames);
	assign rel_o     = ceil_order(req.release_size);
	assign sz_m1     = req.release_size - SIZE_W'(1);
	assign alloc_bad = (req.request_frames == '0) ||
		(req.request_frames > SIZE_W'(FRAMES));
	assign rel_bad   = (req.release_size == '0) || ((req.release_size & sz_m1) != '0) ||
		(req.release_size > SIZE_W'(FRAMES)) ||
		((SIZE_W'(req.release_start) & sz_m1) != '0) ||
		((7'(req.release_start) + 7'(req.release_size)) > 7'(FRAMES));

	// Examine the row just read
	assign scan      = lowest_set(rdata);
	assign buddy_idx = s_q ^ (START_W'(1) << row_q);
	assign split_idx = s_q + (START_W'(1) << row_q);
	assign chk_order = (row_q > o_q) ? row_q : o_q;
	assign conflict  = |(rdata & block_mask(s_q, chk_order));
	assign merge_go  = (row_q < ORD_W'(TOP_ORDER)) && rdata[buddy_idx];

	assign req.ready = (state_q == S_IDLE);

	// Memory requests: read the current row, write back the modified row
	always_comb begin
		mem.we    = 1'b0;
		mem.waddr = row_q;
		mem.wdata = rdata;
		mem.raddr = row_q;
		case (state_q)
			S_INIT: begin
				mem.we    = 1'b1;
				mem.wdata = (row_q == ORD_W'(TOP_ORDER)) ? ROW_W'(1) : '0;
			end
			S_A_CHK: begin
				mem.we    = scan.found;
				mem.wdata = rdata & ~one_bit(scan.idx);
			end
			S_A_SPLIT: begin
				mem.we    = 1'b1;
				mem.wdata = one_bit(split_idx);
			end
			S_M_CHK: begin
				mem.we    = 1'b1;
				mem.wdata = merge_go ? (rdata & ~one_bit(buddy_idx)) :
					(rdata | one_bit(s_q));
			end
			default: begin
				mem.we = 1'b0;
			end
		endcase
	end

	// Result toward the output register
	always_comb begin
		res.valid         = (state_q == S_FIN);
		res.success       = ok_q;
		res.granted_start = '0;
		res.granted_size  = '0;
		if (ok_q && kind_q == KIND_ALLOC) begin
			res.granted_start = s_q;
			res.granted_size  = SIZE_W'(1) << n_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			row_q   <= '0;
			n_q     <= '0;
			o_q     <= '0;
			s_q     <= '0;
			kind_q  <= KIND_ALLOC;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				// clear the free maps, leave the whole pool free
				S_INIT: begin
					if (row_q == ORD_W'(TOP_ORDER)) begin
						row_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						row_q <= row_q + ORD_W'(1);
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						kind_q <= req.kind;
						ok_q   <= 1'b0;
						s_q    <= '0;
						if (req.kind == KIND_ALLOC) begin
							n_q     <= req_n;
							row_q   <= req_n;
							state_q <= alloc_bad ? S_FIN : S_A_RD;
						end else begin
							s_q     <= req.release_start;
							o_q     <= rel_o;
							row_q   <= '0;
							state_q <= rel_bad ? S_FIN : S_R_RD;
						end
					end
				end
				S_A_RD: state_q <= S_A_CHK;
				// take the lowest free block of this order or move up
				S_A_CHK: begin
					if (scan.found) begin
						s_q <= scan.idx;
						if (row_q > n_q) begin
							row_q   <= row_q - ORD_W'(1);
							state_q <= S_A_SPLIT;
						end else begin
							ok_q    <= 1'b1;
							state_q <= S_FIN;
						end
					end else if (row_q == ORD_W'(TOP_ORDER)) begin
						state_q <= S_FIN;
					end else begin
						row_q   <= row_q + ORD_W'(1);
						state_q <= S_A_RD;
					end
				end
				// free the upper half at each lower order
				S_A_SPLIT: begin
					if (row_q == n_q) begin
						ok_q    <= 1'b1;
						state_q <= S_FIN;
					end else begin
						row_q <= row_q - ORD_W'(1);
					end
				end
				S_R_RD: state_q <= S_R_CHK;
				// drop a release that overlaps any free block
				S_R_CHK: begin
					if (conflict) begin
						state_q <= S_FIN;
					end else if (row_q == ORD_W'(TOP_ORDER)) begin
						row_q   <= o_q;
						state_q <= S_M_RD;
					end else begin
						row_q   <= row_q + ORD_W'(1);
						state_q <= S_R_RD;
					end
				end
				S_M_RD: state_q <= S_M_CHK;
				// merge with the free buddy or place the block
				S_M_CHK: begin
					if (merge_go) begin
						s_q     <= s_q & ~(START_W'(1) << row_q);
						row_q   <= row_q + ORD_W'(1);
						state_q <= S_M_RD;
					end else begin
						ok_q    <= 1'b1;
						state_q <= S_FIN;
					end
				end
				// hold until the output register takes the item
				S_FIN: begin
					if (res_take)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/buddy_block_allocator_top.sv @@
// Top level of the buddy block allocator: free map RAM, sequencer and
// output register. Depends on bba_pkg, bba_in_if, bba_out_if, bba_ram, bba_engine.
//
//   channel | dir | payload
//   req     | in  | kind, request_frames, release_start, release_size
//   rsp     | out | success, granted_start, granted_size
//
// One item at a time; each order visited takes a RAM read, then a check and
// write back. A malformed item goes straight from acceptance to its result.
// Allocate searches upward from the requested order, then frees the upper half
// at each split order down to it. Release checks all six rows for an overlap,
// then merges upward order by order; an overlap ends it early. After reset a
// pass writes all six free map rows before req.ready rises. A stalled rsp holds
// its item in the output register while the next request is taken.
`default_nettype none
`include "buddy_block_allocator_top_defines.svh"
module buddy_block_allocator_top (
	input  logic       clk,
	input  logic       arst_n,
	bba_in_if.sink     req,
	bba_out_if.source  rsp
);
	import bba_pkg::*;

	mem_req_t             mem;
	result_t              res;
	logic [ROW_W-1:0]     rdata;
	logic                 out_free;
	logic                 out_valid_q;
	logic                 success_q;
	logic [START_W-1:0]   start_q;
	logic [SIZE_W-1:0]    size_q;

	bba_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ORDERS)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	bba_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rdata    (rdata),
		.mem      (mem),
		.res      (res),
		.res_take (out_free)
	);

	assign out_free = !out_valid_q || rsp.ready;

	// Output register: load a finished item, clear when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid && out_free) begin
			success_q <= res.success;
			start_q   <= res.granted_start;
			size_q    <= res.granted_size;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.success       = success_q;
	assign rsp.granted_start = start_q;
	assign rsp.granted_size  = size_q;

	// Checks
	`BBA_ASSERT_IMPL(a_ready_no_pending, clk, arst_n, req.ready, !res.valid)
	`BBA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	`BBA_ASSERT_IMPL(a_fail_zero, clk, arst_n, res.valid && !res.success,
		res.granted_start == '0 && res.granted_size == '0)
	`BBA_ASSERT_IMPL(a_grant_pow2, clk, arst_n, res.valid && res.granted_size != '0,
		$onehot(res.granted_size) &&
		((res.granted_start & (START_W'(res.granted_size) - START_W'(1))) == '0))
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Testbench for buddy_block_allocator_top: a scripted opening, then random request traffic.
// Each result is checked against a free-map model kept in step with every accepted request.
// Depends on bba_pkg, bba_in_if, bba_out_if and the allocator RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import bba_pkg::*;

	localparam int POOL           = FRAMES;
	localparam int TOP            = TOP_ORDER;
	localparam int RANDOM_ITEMS   = 1600;
	localparam int HOLD_CYCLES    = 200;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PRINT_LIMIT    = 20;

	typedef struct packed {
		logic               kind;
		logic [SIZE_W-1:0]  frames;
		logic [START_W-1:0] rstart;
		logic [SIZE_W-1:0]  rsize;
	} req_t;

	typedef struct packed {
		logic               success;
		logic [START_W-1:0] start;
		logic [SIZE_W-1:0]  size;
	} grant_t;

	typedef struct {
		int start;
		int size;
	} held_t;

	typedef struct {
		logic               kind;
		logic [SIZE_W-1:0]  frames;
		logic [START_W-1:0] rstart;
		logic [SIZE_W-1:0]  rsize;
		bit                 typed;
		logic               w_ok;
		logic [START_W-1:0] w_start;
		logic [SIZE_W-1:0]  w_size;
	} script_row_t;

	// Opening script; typed rows carry their own answer, the others use the model
	script_row_t opening_script [26] = '{
		'{KIND_ALLOC,   32,  0,  0, 1, 1, 0, 32},	// whole pool right after reset
		'{KIND_ALLOC,    1,  0,  0, 1, 0, 0, 0},	// pool exhausted
		'{KIND_RELEASE,  0,  0, 32, 1, 1, 0, 0},	// hand the pool back
		'{KIND_RELEASE,  0,  0, 32, 1, 0, 0, 0},	// double release of the pool
		'{KIND_ALLOC,    0,  0,  0, 1, 0, 0, 0},	// zero request
		'{KIND_ALLOC,   33,  0,  0, 1, 0, 0, 0},	// request above the pool
		'{KIND_ALLOC,   63,  0,  0, 1, 0, 0, 0},
		'{KIND_RELEASE,  0,  0,  0, 1, 0, 0, 0},	// size zero
		'{KIND_RELEASE,  0,  0,  3, 1, 0, 0, 0},	// size not a power of two
		'{KIND_RELEASE,  0,  0, 63, 1, 0, 0, 0},
		'{KIND_RELEASE,  0,  1,  2, 1, 0, 0, 0},	// start not aligned to size
		'{KIND_RELEASE,  0, 16, 32, 1, 0, 0, 0},	// runs past the end of the pool
		'{KIND_RELEASE,  0, 31,  1, 1, 0, 0, 0},	// frame already free
		'{KIND_ALLOC,    1,  0,  0, 0, 0, 0, 0},	// split all the way down
		'{KIND_ALLOC,    3,  0,  0, 0, 0, 0, 0},
		'{KIND_ALLOC,    4,  0,  0, 0, 0, 0, 0},
		'{KIND_ALLOC,    2,  0,  0, 0, 0, 0, 0},
		'{KIND_ALLOC,    1,  0,  0, 0, 0, 0, 0},
		'{KIND_ALLOC,   17,  0,  0, 0, 0, 0, 0},
		'{KIND_ALLOC,   16,  0,  0, 0, 0, 0, 0},
		'{KIND_RELEASE,  0,  4,  4, 0, 0, 0, 0},
		'{KIND_RELEASE,  0,  4,  4, 0, 0, 0, 0},
		'{KIND_RELEASE,  0,  1,  1, 0, 0, 0, 0},	// buddy still held, no merge
		'{KIND_RELEASE,  0,  0,  1, 0, 0, 0, 0},	// merge with the free buddy
		'{KIND_RELEASE,  0,  2,  2, 0, 0, 0, 0},
		'{KIND_RELEASE,  0, 16, 16, 0, 0, 0, 0}
	};

	logic clk;
	logic arst_n;

	bba_in_if  req_ch();
	bba_out_if rsp_ch();

	buddy_block_allocator_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [POOL-1:0] free_map [TOP+1];
	grant_t          pending_grants [$];
	held_t           held_blocks [$];

	int src_idle;
	int snk_idle;
	int hold_requests;
	int errors;
	int n_sent;
	int n_checked;
	int n_granted;
	int n_released;
	int n_refused;

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Model: allocate or release against the free map, return the answer
	function automatic grant_t buddy_predict(input req_t it);
		grant_t g;
		int n, k, s, fk, fs, o, t, z, buddy;
		bit found, clash;
		g = '0;
		fk = 0;
		fs = 0;
		if (it.kind == KIND_ALLOC) begin
			if (it.frames != 0 && it.frames <= POOL) begin
				n = 0;
				while (n < TOP && (1 << n) < it.frames)
					n++;
				found = 1'b0;
				for (k = n; k <= TOP && !found; k++)
					for (s = 0; s < POOL && !found; s += (1 << k))
						if (free_map[k][s]) begin
							found = 1'b1;
							fk = k;
							fs = s;
						end
				if (found) begin
					// take the block, free the upper half at each split
					free_map[fk][fs] = 1'b0;
					for (k = fk - 1; k >= n; k--)
						free_map[k][fs + (1 << k)] = 1'b1;
					g.success = 1'b1;
					g.start = START_W'(fs);
					g.size = SIZE_W'(1 << n);
				end
			end
		end else begin
			z = it.rsize;
			s = it.rstart;
			if (z != 0 && (z & (z - 1)) == 0 && z <= POOL && (s & (z - 1)) == 0
					&& s + z <= POOL) begin
				o = 0;
				while ((1 << o) != z)
					o++;
				// refuse if any frame of the block already sits in a free block
				clash = 1'b0;
				for (k = 0; k <= TOP; k++)
					if (k <= o) begin
						for (t = s; t < s + z; t += (1 << k))
							clash |= free_map[k][t];
					end else begin
						clash |= free_map[k][s & ~((1 << k) - 1)];
					end
				if (!clash) begin
					// merge with the true buddy while it is free
					while (o < TOP) begin
						buddy = s ^ (1 << o);
						if (!free_map[o][buddy])
							break;
						free_map[o][buddy] = 1'b0;
						s &= buddy;
						o++;
					end
					free_map[o][s] = 1'b1;
					g.success = 1'b1;
				end
			end
		end
		return g;
	endfunction

	// Drop held blocks covered by a release; split any block that contains it
	function automatic void forget_released(input int s, input int z);
		int hs, hz;
		for (int i = held_blocks.size() - 1; i >= 0; i--) begin
			hs = held_blocks[i].start;
			hz = held_blocks[i].size;
			if (hs + hz <= s || s + z <= hs)
				continue;
			held_blocks.delete(i);
			if (hz > z)
				for (int p = z; p < hz; p *= 2)
					held_blocks.insert(held_blocks.size(), held_t'{(s ^ p) & ~(p - 1), p});
		end
	endfunction

	// Random request: mostly well-formed traffic, some malformed noise
	function automatic req_t pick_request();
		req_t it;
		int pick, o, idx;
		it.kind = KIND_ALLOC;
		it.frames = SIZE_W'($urandom_range(63));
		it.rstart = START_W'($urandom_range(31));
		it.rsize = SIZE_W'($urandom_range(63));
		pick = $urandom_range(99);
		if (held_blocks.size() != 0 && pick < 40) begin
			idx = $urandom_range(held_blocks.size() - 1);
			it.kind = KIND_RELEASE;
			it.rstart = START_W'(held_blocks[idx].start);
			it.rsize = SIZE_W'(held_blocks[idx].size);
		end else if (pick < 88) begin
			it.kind = KIND_ALLOC;
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: it.frames = SIZE_W'($urandom_range(1, 4));
				6, 7, 8: it.frames = SIZE_W'($urandom_range(1, 16));
				default: it.frames = SIZE_W'($urandom_range(1, 32));
			endcase
		end else begin
			case ($urandom_range(3))
				0: begin
					it.kind = KIND_ALLOC;
					it.frames = $urandom_range(1) ? '0 : SIZE_W'($urandom_range(33, 63));
				end
				1: it.kind = KIND_RELEASE;
				2: begin
					it.kind = KIND_RELEASE;
					it.rsize = SIZE_W'(1 << $urandom_range(5));
				end
				default: begin
					// aligned block anywhere: may hit free space or part of a held one
					o = $urandom_range(5);
					it.kind = KIND_RELEASE;
					it.rsize = SIZE_W'(1 << o);
					it.rstart = START_W'($urandom_range(31) & ~((1 << o) - 1));
				end
			endcase
		end
		return it;
	endfunction

	// Offer one item, then predict its answer once accepted
	task automatic offer_request(input req_t it, input bit typed, input grant_t typed_want);
		grant_t want;
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= it.kind;
		req_ch.request_frames <= it.frames;
		req_ch.release_start <= it.rstart;
		req_ch.release_size <= it.rsize;
		do
			@(posedge clk);
		while (!req_ch.ready);
		want = buddy_predict(it);
		if (typed)
			want = typed_want;
		pending_grants.insert(pending_grants.size(), want);
		n_sent++;
		if (!want.success)
			n_refused++;
		else if (it.kind == KIND_ALLOC) begin
			n_granted++;
			held_blocks.insert(held_blocks.size(), held_t'{int'(want.start), int'(want.size)});
		end else begin
			n_released++;
			forget_released(it.rstart, it.rsize);
		end
	endtask

	// Hold the request side quiet until every answer is back
	task automatic drain_grants();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("%0t: %s expected %0d got %0d", $time, field, want, got);
	endtask

	// Response ready: random stalls, or a long hold-off on request
	initial begin : drive_rsp_ready
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
			end
		end
	end

	// Compare each answer with the oldest expectation
	always @(posedge clk) begin : check_rsp
		grant_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_grants.size() == 0) begin
				errors++;
				if (errors <= PRINT_LIMIT)
					$display("%0t: unexpected item success=%0b start=%0d size=%0d", $time,
						rsp_ch.success, rsp_ch.granted_start, rsp_ch.granted_size);
			end else begin
				want = pending_grants.pop_front();
				n_checked++;
				if (rsp_ch.success !== want.success)
					report_mismatch("success", want.success, rsp_ch.success);
				if (rsp_ch.granted_start !== want.start)
					report_mismatch("granted_start", want.start, rsp_ch.granted_start);
				if (rsp_ch.granted_size !== want.size)
					report_mismatch("granted_size", want.size, rsp_ch.granted_size);
			end
		end
	end

	// Watchdog: end the run after too long without any item moving
	initial begin : watchdog
		int stalls;
		stalls = 0;
		while (stalls < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stalls = 0;
			else
				stalls++;
		end
		$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("tb_top NOT OK");
		$finish;
	end

	// Main sequence
	initial begin : stimulus
		grant_t typed_want;
		req_t   it;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_ALLOC;
		req_ch.request_frames = '0;
		req_ch.release_start = '0;
		req_ch.release_size = '0;
		src_idle = 0;
		snk_idle = 0;
		hold_requests = 0;
		errors = 0;
		n_sent = 0;
		n_checked = 0;
		n_granted = 0;
		n_released = 0;
		n_refused = 0;
		for (int k = 0; k <= TOP; k++)
			free_map[k] = '0;
		free_map[TOP][0] = 1'b1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// walk the opening script
		foreach (opening_script[r]) begin
			it.kind = opening_script[r].kind;
			it.frames = opening_script[r].frames;
			it.rstart = opening_script[r].rstart;
			it.rsize = opening_script[r].rsize;
			typed_want.success = opening_script[r].w_ok;
			typed_want.start = opening_script[r].w_start;
			typed_want.size = opening_script[r].w_size;
			offer_request(it, opening_script[r].typed, typed_want);
		end
		drain_grants();

		// random traffic in three pacing phases
		for (int phase = 0; phase < 3; phase++) begin
			src_idle = (phase == 0) ? 6 : (phase == 1) ? 72 : 0;
			snk_idle = (phase == 0) ? 72 : (phase == 1) ? 6 : 0;
			for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
				if (phase == 2 && i == 200)
					hold_requests++;
				offer_request(pick_request(), 1'b0, '0);
			end
			drain_grants();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d requests and %0d checked answers:", n_sent, n_checked);
		$display("  %0d grants, %0d releases, %0d refusals, under three pacings and a hold-off",
			n_granted, n_released, n_refused);
		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
